FILE: hdl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants of the linear interpolation resampler
// Sample, fraction and step widths, register map, and the structs that
// pass between the sequencer, the interpolation unit and the top level.
// ----------------------------------------------------------------------------
package lir_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_OUTPUTS = 64;
	localparam int STEP_BITS   = 24;

	// working position holds a full step plus a fraction below one
	localparam int POS_BITS  = STEP_BITS + 1;
	localparam int CNT_BITS  = $clog2(MAX_OUTPUTS + 1);
	localparam int PROD_W    = SAMPLE_BITS + FRAC_BITS + 2;

	// configuration port
	localparam int DATA_BITS = 32;
	localparam int ADDR_BITS = 3;
	localparam int IDX_BITS  = ADDR_BITS - 2;
	localparam logic [IDX_BITS-1:0] REG_STEP_RATIO = IDX_BITS'(0);
	localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_ADD
	} lir_state_t;

	// operands for the shared multiply, round and add unit
	typedef struct packed {
		logic                          load;
		logic signed [SAMPLE_BITS-1:0] a;
		logic signed [SAMPLE_BITS-1:0] b;
		logic [FRAC_BITS-1:0]          frac;
	} lir_mac_req_t;

	// push and last flags for one result word handed to the output register
	typedef struct packed {
		logic push;
		logic last;
	} lir_push_t;

endpackage

FILE: hdl/lir_apb_regs.sv
// ----------------------------------------------------------------------------
// lir_apb_regs: configuration register file
// APB-style slave holding the step ratio; pready is tied high.
// ----------------------------------------------------------------------------
module lir_apb_regs import lir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output logic [STEP_BITS-1:0] step_ratio
);

	logic [STEP_BITS-1:0] step_ratio_q;
	logic [IDX_BITS-1:0]  reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_BITS-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ratio_q <= STEP_RESET;
		end else if (wr_en && reg_idx == REG_STEP_RATIO) begin
			step_ratio_q <= pwdata[STEP_BITS-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STEP_RATIO: prdata = DATA_BITS'(step_ratio_q);
			default:        prdata = '0;
		endcase
	end

	assign step_ratio = step_ratio_q;

endmodule

FILE: hdl/lir_interp_unit.sv
// ----------------------------------------------------------------------------
// lir_interp_unit: shared interpolation arithmetic
// Registers (b - a) * frac, then rounds, adds a and clamps to sample range.
// ----------------------------------------------------------------------------
module lir_interp_unit import lir_pkg::*; (
	input  logic                          clk,
	input  lir_mac_req_t                  req,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int SH_W  = PROD_W + 1 - FRAC_BITS;
	localparam int SUM_W = SH_W + 1;
	localparam logic signed [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SUM_MAX =
		{{(SUM_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN =
		{{(SUM_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [FRAC_BITS:0]     frac_s;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      prod_s1;
	logic signed [SAMPLE_BITS-1:0] a_s1;
	logic signed [PROD_W:0]        rsum;
	logic signed [SH_W-1:0]        shifted;
	logic signed [SUM_W-1:0]       sum;

	assign diff   = {req.b[SAMPLE_BITS-1], req.b} - {req.a[SAMPLE_BITS-1], req.a};
	assign frac_s = {1'b0, req.frac};
	assign prod   = diff * frac_s;

	always_ff @(posedge clk) begin
		if (req.load) begin
			prod_s1 <= prod;
			a_s1    <= req.a;
		end
	end

	// round half up, floor shift
	assign rsum    = {prod_s1[PROD_W-1], prod_s1} + RND_HALF;
	assign shifted = rsum[PROD_W:FRAC_BITS];
	assign sum     = {{(SUM_W - SAMPLE_BITS){a_s1[SAMPLE_BITS-1]}}, a_s1}
		+ {shifted[SH_W-1], shifted};

	always_comb begin
		if (sum > SUM_MAX) begin
			result = SUM_MAX[SAMPLE_BITS-1:0];
		end else if (sum < SUM_MIN) begin
			result = SUM_MIN[SAMPLE_BITS-1:0];
		end else begin
			result = sum[SAMPLE_BITS-1:0];
		end
	end

endmodule

FILE: hdl/lir_sequencer.sv
// ----------------------------------------------------------------------------
// lir_sequencer: per-input control of the resampler
// Walks the position accumulator through one or two input intervals and
// drives the shared interpolation unit once per output word.
// ----------------------------------------------------------------------------
module lir_sequencer import lir_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          in_last,
	input  logic [STEP_BITS-1:0]          step_ratio,
	input  logic                          out_free,
	output lir_mac_req_t                  mac_req,
	output lir_push_t                     push
);

	localparam logic [POS_BITS-1:0] ONE_POS = POS_BITS'(1) << FRAC_BITS;
	localparam logic [POS_BITS-1:0] TWO_POS = POS_BITS'(2) << FRAC_BITS;
	localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_OUTPUTS);
	localparam logic [CNT_BITS-1:0] CNT_TOP = CNT_BITS'(MAX_OUTPUTS - 1);

	lir_state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] cur_q, cur_d;
	logic signed [SAMPLE_BITS-1:0] prev_q, prev_d;
	logic                          have_prev_q, have_prev_d;
	logic                          last_q, last_d;
	logic                          phase2_q, phase2_d;
	logic                          final_q, final_d;
	logic [POS_BITS-1:0]           pos_q, pos_d;
	logic [CNT_BITS-1:0]           cnt_q, cnt_d;

	logic [POS_BITS-1:0] next_pos;
	logic [POS_BITS-1:0] pos_end;
	logic                ge_one;
	logic                ge_two;

	assign next_pos = pos_q + POS_BITS'(step_ratio);
	assign ge_one   = next_pos >= ONE_POS;
	assign ge_two   = next_pos >= TWO_POS;
	assign pos_end  = (pos_q >= ONE_POS) ? pos_q - ONE_POS : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			last_q      <= 1'b0;
			phase2_q    <= 1'b0;
			final_q     <= 1'b0;
			pos_q       <= '0;
			cnt_q       <= '0;
		end else begin
			cur_q       <= cur_d;
			prev_q      <= prev_d;
			have_prev_q <= have_prev_d;
			last_q      <= last_d;
			phase2_q    <= phase2_d;
			final_q     <= final_d;
			pos_q       <= pos_d;
			cnt_q       <= cnt_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		have_prev_d  = have_prev_q;
		last_d       = last_q;
		phase2_d     = phase2_q;
		final_d      = final_q;
		pos_d        = pos_q;
		cnt_d        = cnt_q;
		in_stall     = 1'b1;
		mac_req.load = 1'b0;
		mac_req.a    = prev_q;
		mac_req.b    = cur_q;
		mac_req.frac = pos_q[FRAC_BITS-1:0];
		push.push    = 1'b0;
		push.last    = final_q;

		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cur_d    = in_sample;
					last_d   = in_last;
					cnt_d    = '0;
					phase2_d = 1'b0;
					if (have_prev_q) begin
						state_d = ST_CHECK;
					end else begin
						// first sample of a stream: store it
						prev_d      = in_sample;
						have_prev_d = 1'b1;
						if (in_last) begin
							phase2_d = 1'b1;
							state_d  = ST_CHECK;
						end
					end
				end
			end
			ST_CHECK: begin
				if (cnt_q < CNT_MAX && pos_q < ONE_POS) begin
					state_d = ST_MUL;
				end else if (!phase2_q) begin
					prev_d = cur_q;
					pos_d  = pos_end;
					if (last_q) begin
						phase2_d = 1'b1;
					end else begin
						have_prev_d = 1'b1;
						state_d     = ST_IDLE;
					end
				end else begin
					// stream ends: back to start
					prev_d      = '0;
					have_prev_d = 1'b0;
					pos_d       = '0;
					phase2_d    = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			ST_MUL: begin
				mac_req.load = 1'b1;
				// look ahead: is this the final word for the input
				final_d = (cnt_q == CNT_TOP)
					| (phase2_q ? ge_one : (ge_one & (!last_q | ge_two)));
				state_d = ST_ADD;
			end
			ST_ADD: begin
				if (out_free) begin
					push.push = 1'b1;
					cnt_d     = cnt_q + CNT_BITS'(1);
					pos_d     = next_pos;
					state_d   = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler: one-channel linear interpolation resampler
// Converts a sample stream by a programmable step using one shared
// multiply, round and add unit under a small sequencer.
// ----------------------------------------------------------------------------
// Each output word that an input word releases passes once through the
// sequencer loop (position check, multiply into the product register,
// round/add/clamp into the output register), and the output side can hold
// the loop while it stalls; each input interval closes with one more check.
// The first word of a stream that is not marked last is only stored. The
// loop runs through three states around the single shared multiplier.
// in_stall is high from the accepting edge through the closing check that
// follows the loading of the word's last output into the output register;
// that register lets a new input be taken while the final output still
// waits. At most 64 outputs follow one input. step_ratio (unsigned 8.16,
// reset 1.0) is written over the APB-style port at address 0 and must only
// be written while the block is idle.
// ----------------------------------------------------------------------------
module linear_interp_resampler import lir_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_BITS-1:0]          paddr,
	input  logic [DATA_BITS-1:0]          pwdata,
	output logic [DATA_BITS-1:0]          prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          out_last
);

	logic [STEP_BITS-1:0]          step_ratio;
	lir_mac_req_t                  mac_req;
	lir_push_t                     push;
	logic signed [SAMPLE_BITS-1:0] mac_result;
	logic                          out_free;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_last_q;

	lir_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.step_ratio (step_ratio)
	);

	lir_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_sample  (in_sample),
		.in_last    (in_last),
		.step_ratio (step_ratio),
		.out_free   (out_free),
		.mac_req    (mac_req),
		.push       (push)
	);

	lir_interp_unit u_unit (
		.clk    (clk),
		.req    (mac_req),
		.result (mac_result)
	);

	// output register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			// drop the word once taken
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload while stalled, load on push
	always_ff @(posedge clk) begin
		if (push.push) begin
			out_sample_q <= mac_result;
			out_last_q   <= push.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_last   = out_last_q;

endmodule
